// ===== design/bblur_pkg.sv =====
`timescale 1ns / 1ps

package bblur_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int DIM_W       = 11;
   localparam int CHAN_W      = 8;
   localparam int COL_W       = CHAN_W + 2;
   localparam int SUM_W       = CHAN_W + 4;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP       = (1 << RECIP_SHIFT) / 9 + 1;
   localparam int RECIP_W     = 13;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam int CSR_IDX_W   = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
   localparam logic [DIM_W-1:0] WIDTH_MIN    = DIM_W'(3);
   localparam logic [DIM_W-1:0] WIDTH_MAX    = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] HEIGHT_MIN   = DIM_W'(1);
   localparam logic [DIM_W-1:0] HEIGHT_MAX   = DIM_W'(MAX_HEIGHT);

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } rgb_type;

   typedef struct packed {
      rgb_type upper;
      rgb_type middle;
   } line_type;

   typedef struct packed {
      logic [COL_W-1:0] blue;
      logic [COL_W-1:0] green;
      logic [COL_W-1:0] red;
   } colsum_type;

   typedef struct packed {
      logic [SUM_W-1:0] blue;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] red;
   } sum_type;

   typedef logic [2:0] mask_type;

   function automatic colsum_type column_sum(input rgb_type p0, input rgb_type p1,
                                             input rgb_type p2, input mask_type mask);
      colsum_type s;
      rgb_type    z0;
      rgb_type    z1;
      rgb_type    z2;
      z0      = mask[0] ? p0 : '0;
      z1      = mask[1] ? p1 : '0;
      z2      = mask[2] ? p2 : '0;
      s.red   = COL_W'(z0.red) + COL_W'(z1.red) + COL_W'(z2.red);
      s.green = COL_W'(z0.green) + COL_W'(z1.green) + COL_W'(z2.green);
      s.blue  = COL_W'(z0.blue) + COL_W'(z1.blue) + COL_W'(z2.blue);
      return s;
   endfunction

   function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] s);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(s) * PROD_W'(RECIP);
      return prod[RECIP_SHIFT +: CHAN_W];
   endfunction

endpackage

// ===== design/box_blur_3x3_rgb.sv =====
`timescale 1ns / 1ps

// 3x3 box blur over a raster-order RGB pixel stream.
// Input beats (req_) carry one pixel each in raster order; a beat with req_flush
// set takes a raster position and counts as black. After the last pixel of a
// frame, frame_width + 1 flush beats drain the final output row.
// Output beats (rsp_) carry the blurred pixel: each channel is the sum of the
// in-frame 3x3 neighbours divided by 9, truncated; alpha is always 255;
// rsp_frame_end marks the last pixel of the output frame.
// Output pixel (x,y) is caused by the input beat one row plus one pixel later
// and then passes through stage 1, stage 2, stage 3 and the output register.
// Throughput is one beat per cycle unless stalled: the two line buffers share
// one memory with a read and a write port, read at accept, written by stage 1.
// A write on the csr_ port (index 0 width, index 1 height) restarts the frame;
// it is taken only while no beat is in flight.
// Reset restores 640x480 and the start of a frame; line buffers are not cleared.
// When rsp_stall holds a waiting result, the whole pipeline freezes and
// req_stall rises in the same cycle.

module box_blur_3x3_rgb (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bblur_pkg::CHAN_W-1:0]      req_red_in,
   input  logic [bblur_pkg::CHAN_W-1:0]      req_green_in,
   input  logic [bblur_pkg::CHAN_W-1:0]      req_blue_in,
   input  logic                              req_flush,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bblur_pkg::CHAN_W-1:0]      rsp_red_out,
   output logic [bblur_pkg::CHAN_W-1:0]      rsp_green_out,
   output logic [bblur_pkg::CHAN_W-1:0]      rsp_blue_out,
   output logic [bblur_pkg::CHAN_W-1:0]      rsp_alpha_out,
   output logic                              rsp_frame_end,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bblur_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bblur_pkg::DIM_W-1:0]       csr_data
);
   import bblur_pkg::*;

   logic [DIM_W-1:0]  width_ff;
   logic [DIM_W-1:0]  height_ff;
   logic [DIM_W-1:0]  w_used;
   logic [DIM_W-1:0]  h_used;
   logic [ADDR_W-1:0] col_ff;
   logic [ADDR_W-1:0] col_in;
   logic [DIM_W-1:0]  row_ff;
   logic [DIM_W-1:0]  row_in;

   logic adv;
   logic acc;
   logic csr_we;

   logic              first_col;
   logic [DIM_W:0]    row_x;
   logic [DIM_W:0]    h_x;
   logic [DIM_W:0]    row_off;
   logic [DIM_W:0]    row_k;
   logic [DIM_W-1:0]  col_next;
   mask_type          mask0;
   logic              emit0;
   logic              last0;
   rgb_type           pix0;

   line_type          line_mem [MAX_WIDTH];
   line_type          rd_ff;
   line_type          wd_ff;
   line_type          cur;
   line_type          wr_line;

   logic              s1_valid_ff;
   logic [ADDR_W-1:0] s1_col_ff;
   rgb_type           s1_pix_ff;
   mask_type          s1_mask_ff;
   logic              s1_en_left_ff;
   logic              s1_en_right_ff;
   logic              s1_emit_ff;
   logic              s1_last_ff;
   logic              s1_fwd_ff;

   rgb_type           win_ff [6];

   logic              s2_valid_ff;
   logic              s2_last_ff;
   colsum_type        s2_left_ff;
   colsum_type        s2_mid_ff;
   colsum_type        s2_right_ff;

   logic              s3_valid_ff;
   logic              s3_last_ff;
   sum_type           s3_sum_ff;

   logic              rsp_valid_ff;
   logic              rsp_last_ff;
   rgb_type           rsp_pix_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign csr_ready = !(s1_valid_ff || s2_valid_ff || s3_valid_ff || rsp_valid_ff);
   assign req_stall = !adv || (csr_valid && csr_ready);
   assign acc       = req_valid && !req_stall;
   assign csr_we    = csr_valid && csr_ready &&
                      (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT);

   // clamp the frame size
   always_comb begin
      w_used = width_ff;
      if (width_ff < WIDTH_MIN) begin
         w_used = WIDTH_MIN;
      end else if (width_ff > WIDTH_MAX) begin
         w_used = WIDTH_MAX;
      end
      h_used = height_ff;
      if (height_ff < HEIGHT_MIN) begin
         h_used = HEIGHT_MIN;
      end else if (height_ff > HEIGHT_MAX) begin
         h_used = HEIGHT_MAX;
      end
   end

   // raster position, row masks and emit decision of the incoming beat
   always_comb begin
      first_col = (col_ff == '0);
      row_x     = {1'b0, row_ff};
      h_x       = {1'b0, h_used};
      row_off   = first_col ? (DIM_W+1)'(3) : (DIM_W+1)'(2);
      row_k     = '0;
      for (int k = 0; k < 3; k++) begin
         row_k    = row_x + (DIM_W+1)'(k);
         mask0[k] = (row_k >= row_off) && (row_k < h_x + row_off);
      end
      emit0    = first_col ? (row_ff >= DIM_W'(2)) : (row_ff >= DIM_W'(1));
      last0    = first_col && (row_ff >= DIM_W'(2)) && (row_x == h_x + (DIM_W+1)'(1));
      col_next = DIM_W'(col_ff) + DIM_W'(1);
      pix0.red   = req_red_in;
      pix0.green = req_green_in;
      pix0.blue  = req_blue_in;
      if (req_flush || row_ff >= h_used) begin
         pix0 = '0;
      end
      col_in = col_ff;
      row_in = row_ff;
      if (acc) begin
         if (last0) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next >= w_used) begin
            col_in = '0;
            row_in = row_ff + DIM_W'(1);
         end else begin
            col_in = col_next[ADDR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_FRAME_WIDTH) begin
            width_ff <= csr_data;
         end else begin
            height_ff <= csr_data;
         end
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line buffers: read at accept, written back from stage 1
   assign cur            = s1_fwd_ff ? wd_ff : rd_ff;
   assign wr_line.upper  = cur.middle;
   assign wr_line.middle = s1_pix_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_ff <= line_mem[col_ff];
         if (s1_valid_ff) begin
            line_mem[s1_col_ff] <= wr_line;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         wd_ff <= wr_line;
      end
   end

   // stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_fwd_ff   <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= acc;
         s1_fwd_ff   <= acc && s1_valid_ff && (s1_col_ff == col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_col_ff      <= col_ff;
         s1_pix_ff      <= pix0;
         s1_mask_ff     <= mask0;
         s1_en_left_ff  <= first_col || (col_ff >= ADDR_W'(2));
         s1_en_right_ff <= !first_col;
         s1_emit_ff     <= emit0;
         s1_last_ff     <= last0;
      end
   end

   // two-column window, shifted once per beat
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (adv && s1_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= cur.upper;
         win_ff[4] <= cur.middle;
         win_ff[5] <= s1_pix_ff;
      end
   end

   // stage 2: column sums
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_last_ff  <= s1_last_ff;
         s2_left_ff  <= column_sum(win_ff[0], win_ff[1], win_ff[2],
                                   s1_en_left_ff ? s1_mask_ff : '0);
         s2_mid_ff   <= column_sum(win_ff[3], win_ff[4], win_ff[5], s1_mask_ff);
         s2_right_ff <= column_sum(cur.upper, cur.middle, s1_pix_ff,
                                   s1_en_right_ff ? s1_mask_ff : '0);
      end
   end

   // stage 3: window sum
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_last_ff      <= s2_last_ff;
         s3_sum_ff.red   <= SUM_W'(s2_left_ff.red) + SUM_W'(s2_mid_ff.red) +
                            SUM_W'(s2_right_ff.red);
         s3_sum_ff.green <= SUM_W'(s2_left_ff.green) + SUM_W'(s2_mid_ff.green) +
                            SUM_W'(s2_right_ff.green);
         s3_sum_ff.blue  <= SUM_W'(s2_left_ff.blue) + SUM_W'(s2_mid_ff.blue) +
                            SUM_W'(s2_right_ff.blue);
      end
   end

   // output register: divide by 9 through the reciprocal
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_last_ff      <= s3_last_ff;
         rsp_pix_ff.red   <= div9(s3_sum_ff.red);
         rsp_pix_ff.green <= div9(s3_sum_ff.green);
         rsp_pix_ff.blue  <= div9(s3_sum_ff.blue);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_pix_ff.red;
   assign rsp_green_out = rsp_pix_ff.green;
   assign rsp_blue_out  = rsp_pix_ff.blue;
   assign rsp_alpha_out = ALPHA_OPAQUE;
   assign rsp_frame_end = rsp_last_ff;

   // forwarding only happens when a new frame restarts at column zero
   a_fwd_col0 : assert property (@(posedge clock) disable iff (reset)
      s1_fwd_ff |-> (s1_col_ff == '0))
      else $error("line buffer forwarding at nonzero column");

   a_col_range : assert property (@(posedge clock) disable iff (reset)
      DIM_W'(col_ff) < w_used)
      else $error("column counter beyond frame width");

   a_row_range : assert property (@(posedge clock) disable iff (reset)
      {1'b0, row_ff} <= {1'b0, h_used} + (DIM_W+1)'(1))
      else $error("row counter beyond drain row");

   a_last_restart : assert property (@(posedge clock) disable iff (reset)
      (acc && last0 && !csr_we) |=> (col_ff == '0 && row_ff == '0))
      else $error("frame did not restart after last pixel");

   a_csr_restart : assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (col_ff == '0 && row_ff == '0))
      else $error("register write did not restart the frame");

endmodule
